### sv/rabc_pkg.sv
package rabc_pkg;

    // Default geometry
    localparam int DEF_BASE_ROW_PIXELS = 512;
    localparam int DEF_FRAME_ROWS      = 512;

    // Region table
    localparam int REGION_COUNT  = 11;
    localparam int TABLE_ENTRIES = 11;
    localparam int UNIT_W        = 10;

    // Field widths
    localparam int REGION_W = 4;
    localparam int POS_X_W  = 10;
    localparam int POS_Y_W  = 9;
    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 25;   // written flag + three channels

    // Operation codes
    localparam logic OP_BLEND = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Register indexes
    localparam logic REG_WIDE_LAYOUT = 1'b0;

    typedef struct packed {
        logic [UNIT_W-1:0] x;
        logic [UNIT_W-1:0] y;
        logic [UNIT_W-1:0] w;
        logic [UNIT_W-1:0] h;
    } rect_t;

    // Rectangles in 1/256 of base row width (x) and frame rows (y)
    localparam rect_t STD_TABLE [TABLE_ENTRIES] = '{
        '{10'd0,   10'd0,   10'd256, 10'd256},
        '{10'd0,   10'd0,   10'd128, 10'd64},
        '{10'd0,   10'd64,  10'd128, 10'd64},
        '{10'd0,   10'd128, 10'd128, 10'd32},
        '{10'd0,   10'd160, 10'd128, 10'd32},
        '{10'd0,   10'd192, 10'd128, 10'd64},
        '{10'd128, 10'd0,   10'd128, 10'd64},
        '{10'd128, 10'd64,  10'd128, 10'd32},
        '{10'd128, 10'd96,  10'd128, 10'd64},
        '{10'd128, 10'd160, 10'd128, 10'd64},
        '{10'd128, 10'd224, 10'd128, 10'd32}
    };

    localparam rect_t WIDE_TABLE [TABLE_ENTRIES] = '{
        '{10'd0,   10'd0,   10'd512, 10'd256},
        '{10'd0,   10'd0,   10'd128, 10'd64},
        '{10'd0,   10'd64,  10'd128, 10'd64},
        '{10'd0,   10'd128, 10'd128, 10'd32},
        '{10'd256, 10'd0,   10'd256, 10'd256},
        '{10'd0,   10'd192, 10'd128, 10'd64},
        '{10'd128, 10'd0,   10'd128, 10'd64},
        '{10'd128, 10'd64,  10'd128, 10'd32},
        '{10'd128, 10'd96,  10'd128, 10'd64},
        '{10'd128, 10'd160, 10'd128, 10'd64},
        '{10'd128, 10'd224, 10'd128, 10'd32}
    };

    // Controller -> datapath commands
    typedef struct packed {
        logic clear;     // write zero at clear pointer, advance
        logic capture;   // latch input beat
        logic geom;      // region lookup and scaling
        logic coord;     // frame coordinates and range check
        logic index;     // linear address
        logic read;      // frame store read
        logic mix;       // blend products
        logic finish;    // load output, write back
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic clear_last;
    } sts_t;

    // floor(x / 255), exact for x < 65280 (quotient fits 8 bits)
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

### sv/rabc_ctrl.sv
module rabc_ctrl
    import rabc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GEOM,
        ST_COORD,
        ST_INDEX,
        ST_READ,
        ST_MIX,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load_out;

    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (sts.clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_GEOM;
            ST_GEOM:  state_next = ST_COORD;
            ST_COORD: state_next = ST_INDEX;
            ST_INDEX: state_next = ST_READ;
            ST_READ:  state_next = ST_MIX;
            ST_MIX:   state_next = ST_FIN;
            ST_FIN:   if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.clear   = (state_reg == ST_CLEAR);
        cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
        cmd.geom    = (state_reg == ST_GEOM);
        cmd.coord   = (state_reg == ST_COORD);
        cmd.index   = (state_reg == ST_INDEX);
        cmd.read    = (state_reg == ST_READ);
        cmd.mix     = (state_reg == ST_MIX);
        cmd.finish  = load_out;
    end

endmodule

### sv/rabc_datapath.sv
module rabc_datapath
    import rabc_pkg::*;
#(
    parameter int BASE_ROW_PIXELS = DEF_BASE_ROW_PIXELS,
    parameter int FRAME_ROWS      = DEF_FRAME_ROWS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic                wide_layout,
    input  logic                operation,
    input  logic [REGION_W-1:0] region,
    input  logic [POS_X_W-1:0]  pos_x,
    input  logic [POS_Y_W-1:0]  pos_y,
    input  logic [CHAN_W-1:0]   src_c0,
    input  logic [CHAN_W-1:0]   src_c1,
    input  logic [CHAN_W-1:0]   src_c2,
    input  logic [CHAN_W-1:0]   src_alpha,
    output logic [CHAN_W-1:0]   out_c0,
    output logic [CHAN_W-1:0]   out_c1,
    output logic [CHAN_W-1:0]   out_c2,
    output logic [CHAN_W-1:0]   out_alpha,
    output logic                out_of_range
);

    localparam int ROW_MAX     = 2 * BASE_ROW_PIXELS;
    localparam int ROW_W       = $clog2(ROW_MAX + 1);
    localparam int STORE_DEPTH = ROW_MAX * FRAME_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CX_W        = $clog2(ROW_MAX + (1 << POS_X_W));
    localparam int CY_W        = $clog2(FRAME_ROWS + (1 << POS_Y_W));
    localparam int UXP_W       = UNIT_W + $clog2(BASE_ROW_PIXELS + 1);
    localparam int UYP_W       = UNIT_W + $clog2(FRAME_ROWS + 1);
    localparam int LIN_W       = CY_W + ROW_W;

    // Captured item
    logic                op_reg;
    logic [REGION_W-1:0] region_reg;
    logic [POS_X_W-1:0]  px_reg;
    logic [POS_Y_W-1:0]  py_reg;
    logic [CHAN_W-1:0]   s0_reg, s1_reg, s2_reg, alpha_reg;

    // Geometry
    rect_t            rect_sel;
    logic             region_bad;
    logic [UXP_W-1:0] x0_prod, w_prod;
    logic [UYP_W-1:0] y0_prod, h_prod;
    logic [CX_W-1:0]  x0_reg, w_reg;
    logic [CY_W-1:0]  y0_reg, h_reg;
    logic             region_bad_reg;

    // Coordinates
    logic [ROW_W-1:0] row;
    logic [CX_W-1:0]  dx;
    logic [CY_W-1:0]  dy;
    logic             coord_bad;
    logic [CX_W-1:0]  dx_reg;
    logic [CY_W-1:0]  dy_reg;
    logic             bad_reg;

    // Address and store
    logic [LIN_W-1:0]   lin;
    logic [ADDR_W-1:0]  idx_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [PIXEL_W-1:0] mem [STORE_DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [PIXEL_W-1:0] mem_wdata;

    // Blend
    logic [CHAN_W-1:0]  inv_alpha;
    logic [15:0]        sum0_reg, sum1_reg, sum2_reg;
    logic [PIXEL_W-1:0] new_px;
    logic [PIXEL_W-1:0] result;

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= operation;
            region_reg <= region;
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            s0_reg     <= src_c0;
            s1_reg     <= src_c1;
            s2_reg     <= src_c2;
            alpha_reg  <= src_alpha;
        end
    end

    // Region lookup, units scaled to pixels (x * base / 256)
    always_comb
    begin
        region_bad = (32'(region_reg) >= 32'(REGION_COUNT)) ||
                     (32'(region_reg) >= 32'(TABLE_ENTRIES));
        rect_sel = '0;
        if (!region_bad)
        begin
            rect_sel = wide_layout ? WIDE_TABLE[region_reg] : STD_TABLE[region_reg];
        end
        x0_prod = UXP_W'(rect_sel.x) * UXP_W'(BASE_ROW_PIXELS);
        w_prod  = UXP_W'(rect_sel.w) * UXP_W'(BASE_ROW_PIXELS);
        y0_prod = UYP_W'(rect_sel.y) * UYP_W'(FRAME_ROWS);
        h_prod  = UYP_W'(rect_sel.h) * UYP_W'(FRAME_ROWS);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.geom)
        begin
            x0_reg         <= CX_W'(x0_prod >> 8);
            w_reg          <= CX_W'(w_prod >> 8);
            y0_reg         <= CY_W'(y0_prod >> 8);
            h_reg          <= CY_W'(h_prod >> 8);
            region_bad_reg <= region_bad;
        end
    end

    // Frame coordinates and range checks
    assign row = wide_layout ? ROW_W'(ROW_MAX) : ROW_W'(BASE_ROW_PIXELS);

    always_comb
    begin
        if (op_reg == OP_BLEND)
        begin
            dx = CX_W'(x0_reg + CX_W'(px_reg));
            dy = CY_W'(y0_reg + CY_W'(py_reg));
        end
        else
        begin
            dx = CX_W'(px_reg);
            dy = CY_W'(py_reg);
        end
        coord_bad = (dx >= CX_W'(row)) || (dy >= CY_W'(FRAME_ROWS));
        if (op_reg == OP_BLEND)
        begin
            coord_bad = coord_bad || region_bad_reg ||
                        (CX_W'(px_reg) >= w_reg) || (CY_W'(py_reg) >= h_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coord)
        begin
            dx_reg  <= dx;
            dy_reg  <= dy;
            bad_reg <= coord_bad;
        end
    end

    // Linear address
    assign lin = LIN_W'(dy_reg) * LIN_W'(row) + LIN_W'(dx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.index)
        begin
            idx_reg <= ADDR_W'(lin);
        end
    end

    // Clear pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    assign sts.clear_last = (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1));

    // Frame store
    assign mem_we    = cmd.clear || (cmd.finish && !bad_reg && (op_reg == OP_BLEND));
    assign mem_waddr = cmd.clear ? clr_addr_reg : idx_reg;
    assign mem_wdata = cmd.clear ? '0 : new_px;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Blend: dest*(255-a) + src*a per channel
    assign inv_alpha = CHAN_W'(8'd255 - alpha_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mix)
        begin
            sum0_reg <= 16'(rd_data_reg[7:0])   * 16'(inv_alpha) + 16'(s0_reg) * 16'(alpha_reg);
            sum1_reg <= 16'(rd_data_reg[15:8])  * 16'(inv_alpha) + 16'(s1_reg) * 16'(alpha_reg);
            sum2_reg <= 16'(rd_data_reg[23:16]) * 16'(inv_alpha) + 16'(s2_reg) * 16'(alpha_reg);
        end
    end

    assign new_px = {1'b1, div255(sum2_reg), div255(sum1_reg), div255(sum0_reg)};

    always_comb
    begin
        if (bad_reg)
        begin
            result = '0;
        end
        else if (op_reg == OP_READ)
        begin
            result = rd_data_reg;
        end
        else
        begin
            result = new_px;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_c0       <= result[7:0];
            out_c1       <= result[15:8];
            out_c2       <= result[23:16];
            out_alpha    <= result[24] ? 8'd255 : 8'd0;
            out_of_range <= bad_reg;
        end
    end

endmodule

### sv/region_alpha_blend_compositor.sv
// Region alpha-blend compositor. Blend beats (tuser = 0) map a region-relative
// position through the region rectangle table to a frame pixel and blend the
// source colour over it, floor((dest*(255-a) + src*a) / 255) per channel,
// marking the pixel written (alpha 255). Read beats (tuser = 1) return the
// stored pixel at absolute coordinates. Out-of-range items return zeros with
// out_of_range set and leave the store alone. The sequencer walks lookup,
// coordinate check, address multiply, store read, blend multiply and
// write-back over the single-port frame store, one item at a time: the next
// input beat is taken only after the previous item's write-back. A finished
// result sits in the output register, so the next item is accepted while it
// waits; that item holds in write-back only while the previous result is still
// unaccepted. After reset the store is zeroed one entry per cycle, with
// s_tready low; register writes are taken.
module region_alpha_blend_compositor
    import rabc_pkg::*;
#(
    parameter int BASE_ROW_PIXELS = DEF_BASE_ROW_PIXELS,
    parameter int FRAME_ROWS      = DEF_FRAME_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // region[3:0], pos_x[13:4], pos_y[22:14], src_c0[30:23], src_c1[38:31],
    // src_c2[46:39], src_alpha[54:47], pad[55]
    input  logic [55:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_c0[7:0], out_c1[15:8], out_c2[23:16], out_alpha[31:24]
    output logic [31:0] m_tdata,
    // out_of_range[0]
    output logic        m_tuser,

    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t cmd;
    sts_t sts;

    logic        wide_layout_reg;
    logic        cfg_write;
    logic [7:0]  out_c0, out_c1, out_c2, out_alpha;
    logic        out_of_range;

    // Register port: word 0 is wide_layout, other words read zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_layout_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == REG_WIDE_LAYOUT))
        begin
            wide_layout_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_WIDE_LAYOUT) ? {31'd0, wide_layout_reg} : 32'd0;

    // Sequencer
    rabc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Lookup, address, frame store and blend
    rabc_datapath #(
        .BASE_ROW_PIXELS (BASE_ROW_PIXELS),
        .FRAME_ROWS      (FRAME_ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .wide_layout  (wide_layout_reg),
        .operation    (s_tuser),
        .region       (s_tdata[3:0]),
        .pos_x        (s_tdata[13:4]),
        .pos_y        (s_tdata[22:14]),
        .src_c0       (s_tdata[30:23]),
        .src_c1       (s_tdata[38:31]),
        .src_c2       (s_tdata[46:39]),
        .src_alpha    (s_tdata[54:47]),
        .out_c0       (out_c0),
        .out_c1       (out_c1),
        .out_c2       (out_c2),
        .out_alpha    (out_alpha),
        .out_of_range (out_of_range)
    );

    assign m_tdata = {out_alpha, out_c2, out_c1, out_c0};
    assign m_tuser = out_of_range;

endmodule

### tb/sv/rabc_checker.sv
`timescale 1ns / 1ps

module rabc_checker
    import rabc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // region[3:0], pos_x[13:4], pos_y[22:14], src_c0[30:23], src_c1[38:31],
    // src_c2[46:39], src_alpha[54:47], pad[55]
    input  logic [55:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // out_c0[7:0], out_c1[15:8], out_c2[23:16], out_alpha[31:24]
    input  logic [31:0] m_tdata,
    // out_of_range[0]
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          results_owed,
    output int          results_checked,
    output int          rejects_seen
);

    localparam int unsigned ROW_BASE    = DEF_BASE_ROW_PIXELS;
    localparam int unsigned ROWS        = DEF_FRAME_ROWS;
    localparam int unsigned STORE_DEPTH = 2 * ROW_BASE * ROWS;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] alpha;
        logic       oor;
    } pix_result_t;

    // written flag [24], c2 [23:16], c1 [15:8], c0 [7:0]
    bit [24:0]   frame_copy [0:STORE_DEPTH-1];
    logic        wide_layout = 1'b0;
    pix_result_t pending_results [$];

    initial
    begin
        mismatches      = 0;
        results_owed    = 0;
        results_checked = 0;
        rejects_seen    = 0;
    end

    function automatic logic [7:0] blend_chan(input logic [7:0] d, input logic [7:0] s,
                                              input logic [7:0] a);
        logic [31:0] acc;
        acc = 32'(d) * (32'd255 - 32'(a)) + 32'(s) * 32'(a);
        return 8'(acc / 32'd255);
    endfunction

    // Region geometry is in 1/256 of the base row width (x) and frame rows (y).
    function automatic pix_result_t composite_beat(input logic op, input logic [3:0] region,
                                                   input logic [9:0] px, input logic [8:0] py,
                                                   input logic [7:0] s0, input logic [7:0] s1,
                                                   input logic [7:0] s2, input logic [7:0] a);
        pix_result_t res;
        int unsigned row, rx, ry, rw, rh, dx, dy, addr;
        logic [24:0] cur;
        logic        ok;
        res     = '0;
        res.oor = 1'b1;
        ok      = 1'b0;
        dx      = 0;
        dy      = 0;
        row     = wide_layout ? 2 * ROW_BASE : ROW_BASE;
        if (op == OP_READ)
        begin
            dx = px;
            dy = py;
            ok = (dx < row) && (dy < ROWS);
        end
        else if (region < REGION_COUNT)
        begin
            rx = 128;
            ry = 0;
            rw = 128;
            rh = 64;
            case (region)
                4'd0:    begin rx = 0;   ry = 0;   rw = wide_layout ? 512 : 256; rh = 256; end
                4'd1:    begin rx = 0;   ry = 0;   end
                4'd2:    begin rx = 0;   ry = 64;  end
                4'd3:    begin rx = 0;   ry = 128; rh = 32; end
                4'd4:
                begin
                    if (wide_layout)
                    begin
                        rx = 256; ry = 0; rw = 256; rh = 256;
                    end
                    else
                    begin
                        rx = 0; ry = 160; rh = 32;
                    end
                end
                4'd5:    begin rx = 0;   ry = 192; end
                4'd6:    begin rx = 128; ry = 0;   end
                4'd7:    begin rx = 128; ry = 64;  rh = 32; end
                4'd8:    begin rx = 128; ry = 96;  end
                4'd9:    begin rx = 128; ry = 160; end
                default: begin rx = 128; ry = 224; rh = 32; end
            endcase
            if (px < rw * ROW_BASE / 256 && py < rh * ROWS / 256)
            begin
                dx = rx * ROW_BASE / 256 + px;
                dy = ry * ROWS / 256 + py;
                ok = (dx < row) && (dy < ROWS);
            end
        end
        if (ok)
        begin
            addr = dy * row + dx;
            cur  = frame_copy[addr];
            if (op == OP_BLEND)
            begin
                cur = {1'b1, blend_chan(cur[23:16], s2, a), blend_chan(cur[15:8], s1, a),
                       blend_chan(cur[7:0], s0, a)};
                frame_copy[addr] = cur;
            end
            res.c0    = cur[7:0];
            res.c1    = cur[15:8];
            res.c2    = cur[23:16];
            res.alpha = cur[24] ? 8'hFF : 8'h00;
            res.oor   = 1'b0;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        pix_result_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == 3'(REG_WIDE_LAYOUT))
                wide_layout = pwdata[0];

            if (s_tvalid && s_tready)
                pending_results.push_back(composite_beat(s_tuser, s_tdata[3:0], s_tdata[13:4],
                    s_tdata[22:14], s_tdata[30:23], s_tdata[38:31], s_tdata[46:39],
                    s_tdata[54:47]));

            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got data %h oor %b",
                             $time, m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("out_c0", want.c0, m_tdata[7:0]);
                    check_field("out_c1", want.c1, m_tdata[15:8]);
                    check_field("out_c2", want.c2, m_tdata[23:16]);
                    check_field("out_alpha", want.alpha, m_tdata[31:24]);
                    check_field("out_of_range", want.oor, m_tuser);
                    results_checked++;
                    if (want.oor)
                        rejects_seen++;
                end
            end
            results_owed = pending_results.size();
        end
    end

endmodule

### tb/sv/tb_region_alpha_blend_compositor.sv
`timescale 1ns / 1ps

module tb_region_alpha_blend_compositor
    import rabc_pkg::*;
();

    // Generous ceiling on top of both the clear pass after reset and the item traffic.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Extra cycles after the last result to catch stray beats
    localparam int TAIL_CYCLES = 30;
    // Percent chance of an idle cycle on either side
    localparam int IDLE_PCT    = 7;

    localparam logic [2:0] LAYOUT_ADDR   = 3'(REG_WIDE_LAYOUT) << 2;
    localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int  mismatches;
    int  results_owed;
    int  results_checked;
    int  rejects_seen;
    int  cycles = 0;
    int  blends_sent = 0;
    int  reads_sent = 0;
    // no-idle stretch on both sides
    logic quiet = 1'b0;

    region_alpha_blend_compositor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rabc_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .results_owed    (results_owed),
        .results_checked (results_checked),
        .rejects_seen    (rejects_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop if the block hangs (handshake never completes)
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, results_owed);
            $display("tb: failure");
            $finish;
        end
    end

    // Result side back-pressure: ~7% stall, none during the quiet stretch
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);

    // One APB write: setup cycle, then access cycle; lands on the access edge.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Layout select is bit 0; upper bits carry junk the block must ignore.
    task automatic set_layout(input logic wide);
        apb_write(LAYOUT_ADDR, (32'($urandom) << 1) | 32'(wide));
    endtask

    // Drive one input beat and hold it until the block takes it.
    task automatic send_beat(input logic op, input logic [3:0] region,
                             input logic [9:0] px, input logic [8:0] py,
                             input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2, input logic [7:0] a);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, a, c2, c1, c0, py, px, region};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_BLEND)
            blends_sent++;
        else
            reads_sent++;
    endtask

    // Park the stream and wait for every owed result before touching config.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Mix: mostly in-range blends (half on a few hot pixels so they get
    // re-blended), reads biased to those hot pixels, and some raw noise.
    task automatic random_beat();
        logic       op;
        logic [3:0] region;
        logic [9:0] px;
        logic [8:0] py;
        logic [7:0] a;
        int         pick;
        pick   = $urandom_range(99);
        op     = OP_BLEND;
        region = 4'($urandom_range(REGION_COUNT - 1));
        // smallest region is 256x64 pixels, so this always fits
        px     = 10'($urandom_range(255));
        py     = 9'($urandom_range(63));
        a      = 8'($urandom);
        if ($urandom_range(3) == 0)
            a = $urandom_range(1) ? 8'hFF : 8'h00;
        if (pick < 55)
        begin
            if ($urandom_range(1))
            begin
                case ($urandom_range(3))
                    0:       region = 4'd0;
                    1:       region = 4'd1;
                    2:       region = 4'd4;
                    default: region = 4'd6;
                endcase
                px = 10'($urandom_range(7));
                py = 9'($urandom_range(7));
            end
        end
        else if (pick < 85)
        begin
            op = OP_READ;
            if ($urandom_range(1))
            begin
                // hot columns sit at x = 0, 256 and 512 (regions 0/1, 6, wide 4)
                px = 10'($urandom_range(7) + 256 * $urandom_range(2));
                py = 9'($urandom_range(7));
            end
            else
            begin
                px = 10'($urandom);
                py = 9'($urandom);
            end
        end
        else
        begin
            op     = 1'($urandom);
            region = 4'($urandom);
            px     = 10'($urandom);
            py     = 9'($urandom);
        end
        send_beat(op, region, px, py, 8'($urandom), 8'($urandom), 8'($urandom), a);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_BLEND;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Register writes are taken during the post-reset clear pass.
        set_layout(1'b0);

        // ---- standard layout, directed ----
        send_beat(OP_READ,  4'd0,  10'd0,    9'd0,   8'h11, 8'h22, 8'h33, 8'h44); // unwritten
        send_beat(OP_BLEND, 4'd0,  10'd0,    9'd0,   8'hFF, 8'h00, 8'h80, 8'hFF); // opaque
        send_beat(OP_BLEND, 4'd0,  10'd0,    9'd0,   8'h00, 8'hFF, 8'hFF, 8'h00); // transparent
        send_beat(OP_BLEND, 4'd0,  10'd0,    9'd0,   8'h12, 8'h34, 8'h56, 8'h80);
        send_beat(OP_BLEND, 4'd0,  10'd0,    9'd0,   8'hFF, 8'hFF, 8'hFF, 8'h01);
        send_beat(OP_READ,  4'd15, 10'd0,    9'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        // region 10 far corner is the frame corner (511, 511)
        send_beat(OP_BLEND, 4'd10, 10'd255,  9'd63,  8'hA5, 8'h5A, 8'hC3, 8'hFE);
        send_beat(OP_READ,  4'd0,  10'd511,  9'd511, 8'h00, 8'h00, 8'h00, 8'h00);
        // bad region indexes
        send_beat(OP_BLEND, 4'd11, 10'd0,    9'd0,   8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_beat(OP_BLEND, 4'd15, 10'd1023, 9'd511, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // one past the region height / width
        send_beat(OP_BLEND, 4'd3,  10'd0,    9'd64,  8'h10, 8'h20, 8'h30, 8'h40);
        send_beat(OP_BLEND, 4'd6,  10'd256,  9'd0,   8'h10, 8'h20, 8'h30, 8'h40);
        // reads past and at the end of the 512-pixel row
        send_beat(OP_READ,  4'd0,  10'd512,  9'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(OP_READ,  4'd0,  10'd1023, 9'd511, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_beat(OP_READ,  4'd0,  10'd511,  9'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        drain_results();

        // ---- wide layout, directed ----
        set_layout(1'b1);
        send_beat(OP_BLEND, 4'd0,  10'd1023, 9'd511, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_beat(OP_READ,  4'd0,  10'd1023, 9'd511, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(OP_BLEND, 4'd4,  10'd0,    9'd0,   8'h77, 8'h88, 8'h99, 8'hC0);
        send_beat(OP_BLEND, 4'd4,  10'd511,  9'd511, 8'hFF, 8'hFF, 8'hFF, 8'h7F);
        send_beat(OP_BLEND, 4'd4,  10'd512,  9'd0,   8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // old pixels seen through the wider row: (0,0) and std (511,511); also the wide region 4 origin (512,0)
        send_beat(OP_READ,  4'd0,  10'd0,    9'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(OP_READ,  4'd0,  10'd1023, 9'd255, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(OP_READ,  4'd0,  10'd512,  9'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        drain_results();

        // Write to an address with no register behind it; layout must stay wide.
        apb_write(UNMAPPED_ADDR, 32'h0000_0000);

        // ---- random phases, alternating layouts ----
        repeat (210) random_beat();
        drain_results();

        set_layout(1'b0);
        quiet <= 1'b1;
        repeat (210) random_beat();
        drain_results();
        quiet <= 1'b0;

        set_layout(1'b1);
        repeat (210) random_beat();
        drain_results();

        set_layout(1'b0);
        repeat (210) random_beat();
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d blend and %0d read beats over both layouts with random stalls",
                 blends_sent, reads_sent);
        $display("%0d results compared, %0d of them out of range", results_checked,
                 rejects_seen);
        if (mismatches == 0 && results_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
